// ----- hdl/ght_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ght_pkg
// Shared types and constants of the generational handle table.
// ----------------------------------------------------------------------------
package ght_pkg;

  localparam int SLOT_COUNT = 256;
  localparam int SLOT_BITS  = $clog2(SLOT_COUNT);
  localparam int COUNT_BITS = $clog2(SLOT_COUNT + 1);

  typedef enum logic [1:0] {
    CMD_ASSIGN  = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_QUERY   = 2'd2,
    CMD_MARK    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_REUSED   = 3'd1,
    ST_FULL     = 3'd2,
    ST_NO_MATCH = 3'd3,
    ST_PENDING  = 3'd4,
    ST_NULL     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_FETCH
  } state_t;

  typedef struct packed {
    cmd_t        command;
    logic [31:0] owner_id;
    logic [8:0]  slot_index;
    logic [31:0] slot_generation;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic        handle_valid;
    logic [7:0]  slot_out;
    logic [31:0] generation_out;
    logic        exists;
    logic [31:0] owner_out;
  } rsp_t;

  typedef struct packed {
    logic [31:0] owner;
    logic [31:0] generation;
    logic        pending;
  } entry_t;

endpackage

`default_nettype wire

// ----- hdl/ght_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ght_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ght_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/generational_handle_table_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// generational_handle_table_top
// Slot map of generational handles: assign, release, query and mark-destroy.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries one command per
//   transaction; rsp channel (rsp_valid / rsp_stall / rsp) returns exactly one
//   result per command, in order.
//   Slot entries (owner, generation, pending) live in one RAM and the free
//   stack in a second RAM, both with a registered read.
//   The command is registered at the accepting edge and its entry is read;
//   the result is registered from LOOK. An assign that pops the free stack
//   goes on to FETCH, since the popped slot's entry needs a second RAM read.
//   The block works on one command at a time; req_stall is high while a
//   command is in flight and while a finished result is held by rsp_stall.
//   Reset clears the free count and the created-slot count; the RAMs are not
//   cleared, since no entry is read before it is created.
// ----------------------------------------------------------------------------
module generational_handle_table_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire ght_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output ght_pkg::rsp_t      rsp
);

  ght_pkg::state_t                     state, state_next;
  ght_pkg::req_t                       req_q;
  logic [ght_pkg::COUNT_BITS-1:0]      free_count, free_count_next;
  logic [ght_pkg::COUNT_BITS-1:0]      slots_created, slots_created_next;
  logic [ght_pkg::SLOT_BITS-1:0]       new_slot, new_slot_next;

  logic                                accept;
  logic                                fetch_go;
  logic                                rsp_load;
  ght_pkg::rsp_t                       rsp_next;

  logic                                ent_we;
  logic [ght_pkg::SLOT_BITS-1:0]       ent_waddr, ent_raddr;
  ght_pkg::entry_t                     ent_wdata, ent_rd;
  logic                                stk_we;
  logic [ght_pkg::SLOT_BITS-1:0]       stk_waddr, stk_raddr, stk_wdata, stk_rd;

  logic                                slot_ok, gen_eq, match;
  logic [31:0]                         gen_inc, gen_fix;
  logic [ght_pkg::SLOT_BITS-1:0]       req_slot;

  assign req_stall = (state != ght_pkg::S_IDLE) || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;
  assign req_slot  = req_q.slot_index[ght_pkg::SLOT_BITS-1:0];

  // entry RAM reads the requested slot at accept, the popped slot in LOOK
  assign ent_raddr = (state == ght_pkg::S_LOOK) ? stk_rd
                                                : req.slot_index[ght_pkg::SLOT_BITS-1:0];
  assign stk_raddr = free_count[ght_pkg::SLOT_BITS-1:0] - ght_pkg::SLOT_BITS'(1);
  assign stk_waddr = free_count[ght_pkg::SLOT_BITS-1:0];

  ght_ram #(
    .WIDTH ($bits(ght_pkg::entry_t)),
    .DEPTH (ght_pkg::SLOT_COUNT)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rd)
  );

  ght_ram #(
    .WIDTH (ght_pkg::SLOT_BITS),
    .DEPTH (ght_pkg::SLOT_COUNT)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rd)
  );

  assign slot_ok = {{(32 - 9){1'b0}}, req_q.slot_index} <
                   {{(32 - ght_pkg::COUNT_BITS){1'b0}}, slots_created};
  assign gen_eq  = slot_ok && (ent_rd.generation == req_q.slot_generation);
  assign match   = gen_eq && (req_q.owner_id != 32'd0) && (ent_rd.owner == req_q.owner_id);
  assign gen_inc = ent_rd.generation + 32'd1;
  // a reused slot never carries generation zero
  assign gen_fix = (ent_rd.generation == 32'd0) ? 32'd1 : ent_rd.generation;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ght_pkg::S_IDLE: begin
        if (accept) begin
          state_next = ght_pkg::S_LOOK;
        end
      end
      ght_pkg::S_LOOK: begin
        state_next = fetch_go ? ght_pkg::S_FETCH : ght_pkg::S_IDLE;
      end
      ght_pkg::S_FETCH: begin
        state_next = ght_pkg::S_IDLE;
      end
      default: begin
        state_next = ght_pkg::S_IDLE;
      end
    endcase
  end

  // datapath and memory writes
  always_comb begin
    ent_we             = 1'b0;
    ent_waddr          = req_slot;
    ent_wdata          = ent_rd;
    stk_we             = 1'b0;
    stk_wdata          = req_slot;
    free_count_next    = free_count;
    slots_created_next = slots_created;
    new_slot_next      = new_slot;
    fetch_go           = 1'b0;
    rsp_load           = 1'b0;
    rsp_next           = '0;
    rsp_next.status    = ght_pkg::ST_OK;

    unique case (state)
      ght_pkg::S_LOOK: begin
        rsp_load = 1'b1;
        if (req_q.command == ght_pkg::CMD_QUERY) begin
          rsp_next.status = gen_eq ? ght_pkg::ST_OK : ght_pkg::ST_NO_MATCH;
          if (match) begin
            rsp_next.handle_valid   = 1'b1;
            rsp_next.slot_out       = req_q.slot_index[7:0];
            rsp_next.generation_out = req_q.slot_generation;
          end
          if (gen_eq && !ent_rd.pending) begin
            rsp_next.owner_out = ent_rd.owner;
            rsp_next.exists    = ent_rd.owner != 32'd0;
          end
        end else if (req_q.owner_id == 32'd0) begin
          rsp_next.status = ght_pkg::ST_NULL;
        end else begin
          unique case (req_q.command)
            ght_pkg::CMD_ASSIGN: begin
              if (match) begin
                ent_we                  = 1'b1;
                ent_wdata.pending       = 1'b0;
                rsp_next.status         = ght_pkg::ST_REUSED;
                rsp_next.handle_valid   = 1'b1;
                rsp_next.slot_out       = req_q.slot_index[7:0];
                rsp_next.generation_out = req_q.slot_generation;
              end else if (free_count != '0) begin
                // pop: entry of the popped slot is read this cycle
                rsp_load        = 1'b0;
                fetch_go        = 1'b1;
                free_count_next = free_count - ght_pkg::COUNT_BITS'(1);
                new_slot_next   = stk_rd;
              end else if (slots_created < ght_pkg::COUNT_BITS'(ght_pkg::SLOT_COUNT)) begin
                ent_we                  = 1'b1;
                ent_waddr               = slots_created[ght_pkg::SLOT_BITS-1:0];
                ent_wdata.owner         = req_q.owner_id;
                ent_wdata.generation    = 32'd1;
                ent_wdata.pending       = 1'b0;
                slots_created_next      = slots_created + ght_pkg::COUNT_BITS'(1);
                rsp_next.handle_valid   = 1'b1;
                rsp_next.slot_out       = 8'(slots_created[ght_pkg::SLOT_BITS-1:0]);
                rsp_next.generation_out = 32'd1;
              end else begin
                rsp_next.status = ght_pkg::ST_FULL;
              end
            end
            ght_pkg::CMD_RELEASE: begin
              if (!match) begin
                rsp_next.status = ght_pkg::ST_NO_MATCH;
              end else begin
                ent_we               = 1'b1;
                ent_wdata.owner      = 32'd0;
                ent_wdata.pending    = 1'b0;
                ent_wdata.generation = (gen_inc == 32'd0) ? 32'd1 : gen_inc;
                if (free_count < ght_pkg::COUNT_BITS'(ght_pkg::SLOT_COUNT)) begin
                  stk_we          = 1'b1;
                  free_count_next = free_count + ght_pkg::COUNT_BITS'(1);
                end
              end
            end
            default: begin
              // mark for destroy
              if (!match) begin
                rsp_next.status = ght_pkg::ST_NO_MATCH;
              end else begin
                rsp_next.handle_valid   = 1'b1;
                rsp_next.slot_out       = req_q.slot_index[7:0];
                rsp_next.generation_out = req_q.slot_generation;
                if (ent_rd.pending) begin
                  rsp_next.status = ght_pkg::ST_PENDING;
                end else begin
                  ent_we            = 1'b1;
                  ent_wdata.pending = 1'b1;
                end
              end
            end
          endcase
        end
      end
      ght_pkg::S_FETCH: begin
        rsp_load                = 1'b1;
        ent_we                  = 1'b1;
        ent_waddr               = new_slot;
        ent_wdata.owner         = req_q.owner_id;
        ent_wdata.generation    = gen_fix;
        ent_wdata.pending       = 1'b0;
        rsp_next.handle_valid   = 1'b1;
        rsp_next.slot_out       = 8'(new_slot);
        rsp_next.generation_out = gen_fix;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ght_pkg::S_IDLE;
      free_count    <= '0;
      slots_created <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      free_count    <= free_count_next;
      slots_created <= slots_created_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    new_slot <= new_slot_next;
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ght_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ght_checker
// Port-level checks of the generational handle table, bound to the top level.
// ----------------------------------------------------------------------------
module ght_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          rsp_valid,
  input wire logic          rsp_stall,
  input wire ght_pkg::rsp_t rsp
);

  // a held result stays until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result dropped or changed while stalled");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.handle_valid |-> rsp.slot_out == 8'd0 && rsp.generation_out == 32'd0)
    else $error("invalid handle with nonzero slot or generation");

  // stored generations never reach zero
  a_valid_gen: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.handle_valid |-> rsp.generation_out != 32'd0)
    else $error("valid handle with generation zero");

  a_exists_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.exists |-> rsp.status == ght_pkg::ST_OK && rsp.owner_out != 32'd0)
    else $error("exists reported without a matching live owner");

  a_null_invalid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ght_pkg::ST_NULL |-> !rsp.handle_valid && !rsp.exists)
    else $error("null owner produced a handle");

endmodule

bind generational_handle_table_top ght_checker u_ght_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the generational handle table. A predictor keeps
// its own copy of the slot entries and the free stack, works out the result
// of every command and queues it at acceptance; the monitor compares each
// result field by field, in order. Stimulus is a directed opening followed by
// random handle traffic that fills the table, then drains it, with random
// idle and stall bursts on both channels.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam int QUIET_TAIL  = 60;
  localparam int DRAIN_WAIT  = 12;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  ght_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  ght_pkg::rsp_t rsp;

  generational_handle_table_top dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor copy of the table
  bit [31:0] owner_mem [ght_pkg::SLOT_COUNT];
  bit [31:0] gen_mem [ght_pkg::SLOT_COUNT];
  bit        pend_mem [ght_pkg::SLOT_COUNT];
  bit [7:0]  stack_mem [ght_pkg::SLOT_COUNT];
  int        free_cnt = 0;
  int        created_cnt = 0;

  ght_pkg::req_t pending_reqs[$];
  ght_pkg::rsp_t predicted_rsps[$];
  ght_pkg::rsp_t awaited_rsps[$];

  int   error_count = 0;
  int   rsp_count = 0;
  int   cycle_count = 0;
  int   idle_left = 0;
  int   stall_left = 0;
  ght_pkg::rsp_t awaited_head;

  function automatic ght_pkg::rsp_t predict_handle(ght_pkg::req_t r);
    ght_pkg::rsp_t o;
    logic [7:0] s;
    logic [7:0] ns;
    bit in_range;
    bit match;
    bit alloc;
    o = '0;
    s = r.slot_index[7:0];
    in_range = r.slot_index < created_cnt;
    match = (r.owner_id != 0) && in_range && owner_mem[s] == r.owner_id &&
            gen_mem[s] == r.slot_generation;
    alloc = 1'b0;
    ns = '0;
    if (match) begin
      o.handle_valid = 1'b1;
      o.slot_out = s;
      o.generation_out = r.slot_generation;
    end
    if (r.command == ght_pkg::CMD_QUERY) begin
      o.status = (in_range && gen_mem[s] == r.slot_generation) ? ght_pkg::ST_OK
                                                               : ght_pkg::ST_NO_MATCH;
      if (in_range && gen_mem[s] == r.slot_generation && !pend_mem[s]) begin
        o.owner_out = owner_mem[s];
        o.exists = owner_mem[s] != 0;
      end
    end else if (r.owner_id == 0) begin
      o = '0;
      o.status = ght_pkg::ST_NULL;
    end else if (!match && r.command != ght_pkg::CMD_ASSIGN) begin
      o.status = ght_pkg::ST_NO_MATCH;
    end else begin
      case (r.command)
        ght_pkg::CMD_ASSIGN: begin
          if (match) begin
            pend_mem[s] = 1'b0;
            o.status = ght_pkg::ST_REUSED;
          end else if (free_cnt > 0) begin
            free_cnt--;
            ns = stack_mem[free_cnt];
            alloc = 1'b1;
          end else if (created_cnt < ght_pkg::SLOT_COUNT) begin
            ns = 8'(created_cnt);
            created_cnt++;
            gen_mem[ns] = 32'd1;
            alloc = 1'b1;
          end else begin
            o.status = ght_pkg::ST_FULL;
          end
          if (alloc) begin
            owner_mem[ns] = r.owner_id;
            pend_mem[ns] = 1'b0;
            if (gen_mem[ns] == 0) gen_mem[ns] = 32'd1;
            o.status = ght_pkg::ST_OK;
            o.handle_valid = 1'b1;
            o.slot_out = ns;
            o.generation_out = gen_mem[ns];
          end
        end
        ght_pkg::CMD_RELEASE: begin
          owner_mem[s] = '0;
          pend_mem[s] = 1'b0;
          gen_mem[s] = gen_mem[s] + 32'd1;
          // generation 0 is never handed out
          if (gen_mem[s] == 0) gen_mem[s] = 32'd1;
          if (free_cnt < ght_pkg::SLOT_COUNT) begin
            stack_mem[free_cnt] = s;
            free_cnt++;
          end
          o = '0;
          o.status = ght_pkg::ST_OK;
        end
        default: begin
          if (pend_mem[s]) begin
            o.status = ght_pkg::ST_PENDING;
          end else begin
            pend_mem[s] = 1'b1;
            o.status = ght_pkg::ST_OK;
          end
        end
      endcase
    end
    return o;
  endfunction

  task automatic push_item(ght_pkg::req_t r);
    pending_reqs = {pending_reqs, r};
    predicted_rsps = {predicted_rsps, predict_handle(r)};
  endtask

  task automatic put(ght_pkg::cmd_t c, logic [31:0] own, logic [8:0] s, logic [31:0] g);
    ght_pkg::req_t r;
    r.command = c;
    r.owner_id = own;
    r.slot_index = s;
    r.slot_generation = g;
    push_item(r);
  endtask

  task automatic make_random(int assign_pct);
    ght_pkg::req_t r;
    int form;
    int tries;
    logic [7:0] s;
    bit found;
    found = 1'b0;
    s = '0;
    // look for a slot that currently has an owner
    for (tries = 0; tries < 8 && !found && created_cnt > 0; tries++) begin
      s = 8'($urandom_range(0, created_cnt - 1));
      found = owner_mem[s] != 0;
    end
    r.owner_id = $urandom;
    r.slot_index = 9'($urandom_range(0, 511));
    r.slot_generation = $urandom;
    form = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < assign_pct) begin
      r.command = ght_pkg::CMD_ASSIGN;
      if (form < 10 && found) begin
        r.owner_id = owner_mem[s];
        r.slot_index = {1'b0, s};
        r.slot_generation = gen_mem[s];
      end else if (form < 14) begin
        r.owner_id = '0;
      end else if (r.owner_id == 0) begin
        r.owner_id = 32'd1;
      end
    end else begin
      r.command = ght_pkg::cmd_t'($urandom_range(1, 3));
      if (found && form < 90) begin
        r.owner_id = owner_mem[s];
        r.slot_index = {1'b0, s};
        r.slot_generation = gen_mem[s];
        // broken handles
        if (form >= 75) begin
          case (form % 4)
            0: r.owner_id = '0;
            1: r.slot_generation = gen_mem[s] + 32'd1;
            2: r.slot_generation = gen_mem[s] - 32'd1;
            default: r.owner_id = owner_mem[s] ^ (32'd1 << $urandom_range(0, 31));
          endcase
        end
      end
    end
    push_item(r);
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch: %s", what);
    error_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0h want %0h", rsp_count, name, got,
                                want));
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      idle_left <= 0;
    end else begin
      if (req_valid && !req_stall)
        awaited_rsps = {awaited_rsps, predicted_rsps.pop_front()};
      if (!req_valid || !req_stall) begin
        if (idle_left > 0) begin
          idle_left <= idle_left - 1;
          req_valid <= 1'b0;
        end else if (pending_reqs.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
          idle_left <= $urandom_range(0, 3);
          req_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          req <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (awaited_rsps.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing awaited", rsp_count));
        end else begin
          awaited_head = awaited_rsps.pop_front();
          check_field("status", rsp.status, awaited_head.status);
          check_field("handle_valid", rsp.handle_valid, awaited_head.handle_valid);
          check_field("slot_out", rsp.slot_out, awaited_head.slot_out);
          check_field("generation_out", rsp.generation_out, awaited_head.generation_out);
          check_field("exists", rsp.exists, awaited_head.exists);
          check_field("owner_out", rsp.owner_out, awaited_head.owner_out);
        end
        rsp_count++;
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        rsp_stall <= 1'b1;
      end else if (pending_reqs.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 3);
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int i;
    put(ght_pkg::CMD_QUERY, 32'h0, 9'd0, 32'd0);                     // empty table
    put(ght_pkg::CMD_ASSIGN, 32'h0, 9'd0, 32'd0);                    // null owner
    put(ght_pkg::CMD_RELEASE, 32'h0, 9'd0, 32'd0);
    put(ght_pkg::CMD_MARK, 32'h0, 9'd0, 32'd0);
    put(ght_pkg::CMD_ASSIGN, 32'hFFFF_FFFF, 9'h1FF, 32'hFFFF_FFFF);  // fresh slot 0
    put(ght_pkg::CMD_ASSIGN, 32'h1, 9'd0, 32'd1);                    // fresh slot 1
    put(ght_pkg::CMD_ASSIGN, 32'hFFFF_FFFF, 9'd0, 32'd1);            // own handle
    put(ght_pkg::CMD_QUERY, 32'hFFFF_FFFF, 9'd0, 32'd1);
    put(ght_pkg::CMD_QUERY, 32'h0, 9'd0, 32'd1);
    put(ght_pkg::CMD_MARK, 32'hFFFF_FFFF, 9'd0, 32'd1);
    put(ght_pkg::CMD_MARK, 32'hFFFF_FFFF, 9'd0, 32'd1);              // already pending
    put(ght_pkg::CMD_QUERY, 32'hFFFF_FFFF, 9'd0, 32'd1);             // owner hidden
    put(ght_pkg::CMD_ASSIGN, 32'hFFFF_FFFF, 9'd0, 32'd1);            // clears pending
    put(ght_pkg::CMD_RELEASE, 32'hFFFF_FFFF, 9'd0, 32'd2);           // wrong generation
    put(ght_pkg::CMD_RELEASE, 32'hFFFF_FFFF, 9'd0, 32'd1);
    put(ght_pkg::CMD_QUERY, 32'hFFFF_FFFF, 9'd0, 32'd1);             // stale handle
    put(ght_pkg::CMD_QUERY, 32'h0, 9'd0, 32'd2);                     // freed slot
    put(ght_pkg::CMD_ASSIGN, 32'h1234_5678, 9'd0, 32'd0);            // pops slot 0
    put(ght_pkg::CMD_MARK, 32'h2, 9'd1, 32'd1);                      // wrong owner
    put(ght_pkg::CMD_QUERY, 32'hFFFF_FFFF, 9'h1FF, 32'hFFFF_FFFF);   // out of range
    put(ght_pkg::CMD_RELEASE, 32'h1, 9'h100, 32'd1);
    put(ght_pkg::CMD_MARK, 32'h1, 9'd1, 32'd1);
    put(ght_pkg::CMD_RELEASE, 32'h1, 9'd1, 32'd1);                   // pending slot
    put(ght_pkg::CMD_QUERY, 32'h1, 9'd1, 32'd2);
    // mixed traffic, then fill the table past full, then drain it
    for (i = 0; i < 425; i++)
      make_random(i < 70 ? 40 : (i < 370 ? 95 : 10));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || predicted_rsps.size() != 0 || req_valid ||
           awaited_rsps.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (awaited_rsps.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_rsps.size()));
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
